@@ rtl/b64sd_pkg.sv @@
// Shared constants and character mapping for the Base64 stream decoder.
`default_nettype none
package b64sd_pkg;

   localparam logic [7:0] CHAR_PAD   = 8'h3D;   // '='
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;   // '+'
   localparam logic [7:0] CHAR_SLASH = 8'h2F;   // '/'
   localparam logic [7:0] CHAR_DOT   = 8'h2E;   // '.'
   localparam logic [7:0] CHAR_DASH  = 8'h2D;   // '-'

   localparam logic [5:0] SEXTET_62    = 6'd62;
   localparam logic [5:0] SEXTET_63    = 6'd63;
   localparam logic [5:0] LOWER_OFFSET = 6'd26;
   localparam logic [5:0] DIGIT_OFFSET = 6'd52;

   localparam logic       MODE_STANDARD = 1'b0;

   typedef logic [1:0] grp_pos_type;

   localparam grp_pos_type POS_LAST = 2'd3;
   localparam grp_pos_type POS_THIRD = 2'd2;

   function automatic logic [5:0] map_char(input logic [7:0] c, input logic mode);
      logic [7:0] sym62;
      logic [7:0] sym63;
      logic [7:0] diff;
      logic [5:0] v;
      sym62 = (mode == MODE_STANDARD) ? CHAR_PLUS  : CHAR_DOT;
      sym63 = (mode == MODE_STANDARD) ? CHAR_SLASH : CHAR_DASH;
      diff  = 8'd0;
      if (c == CHAR_PAD) begin
         v = 6'd0;
      end else if (c == sym62) begin
         v = SEXTET_62;
      end else if (c == sym63) begin
         v = SEXTET_63;
      end else if (c inside {[8'h41:8'h5A]}) begin
         diff = c - 8'h41;
         v    = diff[5:0];
      end else if (c inside {[8'h61:8'h7A]}) begin
         diff = c - 8'h61;
         v    = diff[5:0] + LOWER_OFFSET;
      end else if (c inside {[8'h30:8'h39]}) begin
         diff = c - 8'h30;
         v    = diff[5:0] + DIGIT_OFFSET;
      end else begin
         v = c[5:0];
      end
      return v;
   endfunction

endpackage
`default_nettype wire

@@ rtl/base64_stream_decoder.sv @@
// Base64 character-stream decoder: one character per request, up to three bytes per group.
// The first byte of a group is valid in the cycle after its fourth character is taken.
// Throughput: one character per cycle; the group buffer drains one byte per cycle while
// rsp_tready is high; a fourth character waits while the previous group's bytes remain buffered.
// Reset: synchronous, active high; clears group state, the buffer count and the mode to '+' '/'.
`default_nettype none
module base64_stream_decoder
   import b64sd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_wen,
   input  wire logic       csr_wdata,    // alphabet_mode
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,    // [7:0] char_code
   input  wire logic       req_tlast,    // end_of_message
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,    // [7:0] data_byte
   output logic            rsp_tlast,    // last_of_run
   output logic [0:0]      rsp_tuser     // [0] message_done
);

   logic        mode_ff;
   logic [17:0] acc_ff, acc_in;
   grp_pos_type pos_ff, pos_in;
   logic        third_pad_ff, third_pad_in;
   logic [23:0] grp_bits_ff, grp_bits_in;
   logic [1:0]  grp_cnt_ff, grp_cnt_in;
   logic        grp_eom_ff, grp_eom_in;

   logic        req_fire;
   logic        rsp_fire;
   logic        is_pad;
   logic [5:0]  sextet;

   assign sextet     = map_char(req_tdata, mode_ff);
   assign is_pad     = (req_tdata == CHAR_PAD);
   assign req_tready = (pos_ff != POS_LAST) || (grp_cnt_ff == 2'd0);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = (grp_cnt_ff != 2'd0);
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = grp_bits_ff[23:16];
   assign rsp_tlast  = (grp_cnt_ff == 2'd1);
   assign rsp_tuser  = rsp_tlast && grp_eom_ff;

   always_comb begin
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      third_pad_in = third_pad_ff;
      grp_bits_in  = grp_bits_ff;
      grp_cnt_in   = grp_cnt_ff;
      grp_eom_in   = grp_eom_ff;
      if (rsp_fire) begin
         grp_bits_in = {grp_bits_ff[15:0], 8'd0};
         grp_cnt_in  = grp_cnt_ff - 2'd1;
      end
      if (req_fire) begin
         if (pos_ff != POS_LAST) begin
            if (pos_ff == POS_THIRD) begin
               third_pad_in = is_pad;
            end
            acc_in = {acc_ff[11:0], sextet};
            pos_in = pos_ff + 2'd1;
            if (req_tlast) begin
               acc_in       = 18'd0;
               pos_in       = 2'd0;
               third_pad_in = 1'b0;
            end
         end else begin
            // load the finished group; buffer is empty here
            grp_bits_in  = {acc_ff, sextet};
            grp_eom_in   = req_tlast;
            if (third_pad_ff) begin
               grp_cnt_in = 2'd1;
            end else if (is_pad) begin
               grp_cnt_in = 2'd2;
            end else begin
               grp_cnt_in = 2'd3;
            end
            acc_in       = 18'd0;
            pos_in       = 2'd0;
            third_pad_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_STANDARD;
         acc_ff       <= 18'd0;
         pos_ff       <= 2'd0;
         third_pad_ff <= 1'b0;
         grp_cnt_ff   <= 2'd0;
         grp_eom_ff   <= 1'b0;
      end else begin
         if (csr_wen) begin
            mode_ff <= csr_wdata;
         end
         acc_ff       <= acc_in;
         pos_ff       <= pos_in;
         third_pad_ff <= third_pad_in;
         grp_cnt_ff   <= grp_cnt_in;
         grp_eom_ff   <= grp_eom_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_bits_ff <= grp_bits_in;
   end

   a_load_into_empty: assert property (@(posedge clock) disable iff (reset)
      (req_fire && pos_ff == POS_LAST) |-> (grp_cnt_ff == 2'd0))
      else $error("group loaded while buffer still holds bytes");

   a_eom_clears_group: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> (pos_ff == 2'd0 && acc_ff == 18'd0))
      else $error("group state not cleared after end of message");

   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tuser[0] |-> rsp_tlast)
      else $error("message_done without last_of_run");

   a_partial_no_output: assert property (@(posedge clock) disable iff (reset)
      (req_fire && pos_ff != POS_LAST && !rsp_fire) |=> $stable(grp_cnt_ff))
      else $error("partial group changed the output buffer");

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for base64_stream_decoder: directed and random character streams.
`timescale 1ns / 1ps
module tb_top
   import b64sd_pkg::*;
();

   localparam int          DRAIN_CYCLES = 8;
   localparam logic [7:0]  CHAR_UPPER_A = 8'h41;
   localparam logic [7:0]  CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0]  CHAR_LOWER_A = 8'h61;
   localparam logic [7:0]  CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0]  CHAR_DIGIT_0 = 8'h30;
   localparam logic [7:0]  CHAR_DIGIT_9 = 8'h39;
   localparam logic        MODE_VARIANT = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_of_run;
      logic       message_done;
   } decoded_byte_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wen = 1'b0;
   logic       csr_wdata = 1'b0;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic [0:0] rsp_tuser;

   decoded_byte_type pending_bytes[$];
   logic [17:0]   grp_acc = '0;
   grp_pos_type   grp_pos = '0;
   logic          third_pad = 1'b0;
   logic          alpha_mode = MODE_STANDARD;

   int  fail_count = 0;
   int  bytes_checked = 0;
   int  chars_sent = 0;
   int  groups_decoded = 0;
   int  mode_writes = 0;
   bit  src_gaps_on = 1'b1;
   bit  sink_gaps_on = 1'b1;
   int  sink_stall_left = 0;

   base64_stream_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("base64_stream_decoder regression: fail");
      $finish;
   end

   function automatic logic [5:0] sextet_of(input logic [7:0] c);
      logic [7:0] sym62;
      logic [7:0] sym63;
      sym62 = (alpha_mode == MODE_STANDARD) ? CHAR_PLUS : CHAR_DOT;
      sym63 = (alpha_mode == MODE_STANDARD) ? CHAR_SLASH : CHAR_DASH;
      if (c == CHAR_PAD) return 6'd0;
      if (c == sym62) return SEXTET_62;
      if (c == sym63) return SEXTET_63;
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return 6'(c - CHAR_UPPER_A);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return 6'(c - CHAR_LOWER_A) + LOWER_OFFSET;
      if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) return 6'(c - CHAR_DIGIT_0) + DIGIT_OFFSET;
      return c[5:0];
   endfunction

   function automatic logic [7:0] char_for_sextet(input logic [5:0] v);
      if (v == SEXTET_62) return (alpha_mode == MODE_STANDARD) ? CHAR_PLUS : CHAR_DOT;
      if (v == SEXTET_63) return (alpha_mode == MODE_STANDARD) ? CHAR_SLASH : CHAR_DASH;
      if (v < LOWER_OFFSET) return CHAR_UPPER_A + 8'(v);
      if (v < DIGIT_OFFSET) return CHAR_LOWER_A + 8'(v - LOWER_OFFSET);
      return CHAR_DIGIT_0 + 8'(v - DIGIT_OFFSET);
   endfunction

   function automatic int gap_length(input int zero_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < zero_pct) return 0;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 92) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   task automatic decode_char(input logic [7:0] c, input logic eom);
      logic [5:0]    v;
      logic [23:0]   bits;
      int            nbytes;
      logic          is_pad;
      decoded_byte_type d;
      is_pad = (c == CHAR_PAD);
      v = sextet_of(c);
      if (grp_pos != POS_LAST) begin
         if (grp_pos == POS_THIRD) third_pad = is_pad;
         grp_acc = {grp_acc[11:0], v};
         grp_pos = grp_pos + 2'd1;
      end else begin
         bits = {grp_acc, v};
         nbytes = third_pad ? 1 : (is_pad ? 2 : 3);
         for (int k = 0; k < nbytes; k++) begin
            d.data_byte    = bits[23 - 8 * k -: 8];
            d.last_of_run  = (k == nbytes - 1);
            d.message_done = d.last_of_run && eom;
            pending_bytes.insert(pending_bytes.size(), d);
         end
         groups_decoded++;
         eom = 1'b1;
      end
      if (eom) begin
         grp_acc   = '0;
         grp_pos   = '0;
         third_pad = 1'b0;
      end
   endtask

   task automatic send_char(input logic [7:0] c, input logic eom);
      int n;
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eom;
      do @(posedge clock); while (!req_tready);
      decode_char(c, eom);
      chars_sent++;
      n = src_gaps_on ? gap_length(55) : 0;
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s, input logic eom_at_end);
      for (int i = 0; i < s.len(); i++) send_char(s[i], eom_at_end && (i == s.len() - 1));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic m);
      csr_wen   <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_wen    <= 1'b0;
      alpha_mode = m;
      mode_writes++;
   endtask

   task automatic send_random_group();
      logic [7:0] chars[4];
      int         pads;
      int         r;
      for (int i = 0; i < 4; i++) chars[i] = char_for_sextet(6'($urandom_range(0, 63)));
      r = $urandom_range(0, 99);
      pads = (r < 65) ? 0 : ((r < 85) ? 1 : 2);
      if (pads >= 1) chars[3] = CHAR_PAD;
      if (pads == 2) chars[2] = CHAR_PAD;
      for (int i = 0; i < 4; i++)
         send_char(chars[i], (i == 3) && ($urandom_range(0, 3) == 0));
   endtask

   task automatic send_noise();
      int n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
         send_char(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
   endtask

   task automatic test_standard_alphabet();
      set_mode(MODE_STANDARD);
      send_text("AZaz", 1'b0);
      send_text("09+/", 1'b0);
      send_text("QQ==", 1'b0);
      send_text("QUI=", 1'b1);
      send_char(CHAR_PAD, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(8'h00, 1'b0);
      send_char(CHAR_DOT, 1'b0);
      send_text("Zz", 1'b1);
      wait_idle();
   endtask

   task automatic test_variant_alphabet();
      set_mode(MODE_VARIANT);
      send_text(".-+/", 1'b1);
      send_char(CHAR_PAD, 1'b1);
      wait_idle();
   endtask

   task automatic test_random_groups();
      int   phase_start;
      logic m;
      for (int ph = 0; ph < 4; ph++) begin
         m = (ph == 0 || ph == 2) ? MODE_VARIANT :
             ((ph == 1) ? MODE_STANDARD : logic'($urandom_range(0, 1)));
         set_mode(m);
         src_gaps_on  = (ph != 0);
         sink_gaps_on = (ph != 0);
         phase_start  = chars_sent;
         while (chars_sent - phase_start < 20) begin
            if ($urandom_range(0, 99) < 80) send_random_group();
            else send_noise();
            // hold the source until every expected byte has come out of the decoder
            if (ph == 2 && chars_sent - phase_start >= 14 && chars_sent - phase_start < 18)
               wait_idle();
         end
         if (grp_pos != '0) send_char(8'($urandom_range(0, 255)), 1'b1);
         wait_idle();
      end
      sink_gaps_on = 1'b1;
   endtask

   always @(posedge clock) begin : check_rsp
      decoded_byte_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_bytes.size() == 0) begin
               $error("data_byte %02h arrived with nothing expected", rsp_tdata);
               fail_count++;
            end else begin
               want = pending_bytes.pop_front();
               bytes_checked++;
               if (rsp_tdata !== want.data_byte) begin
                  $error("data_byte: expected %02h, got %02h", want.data_byte, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== want.last_of_run) begin
                  $error("last_of_run: expected %0b, got %0b", want.last_of_run, rsp_tlast);
                  fail_count++;
               end
               if (rsp_tuser[0] !== want.message_done) begin
                  $error("message_done: expected %0b, got %0b", want.message_done, rsp_tuser[0]);
                  fail_count++;
               end
            end
         end
         if (sink_stall_left > 0) begin
            sink_stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (sink_gaps_on && $urandom_range(0, 99) < 25) sink_stall_left = gap_length(0);
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_standard_alphabet();
      test_variant_alphabet();
      test_random_groups();
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d characters in %0d decoded groups, %0d bytes checked,", chars_sent,
               groups_decoded, bytes_checked);
      $display("%0d alphabet mode writes, padding, stray characters and message ends.",
               mode_writes);
      if (fail_count == 0) begin
         $display("base64_stream_decoder regression: pass");
      end else begin
         $display("base64_stream_decoder regression: fail");
      end
      $finish;
   end

endmodule
